[src/gsic_pkg.sv]
package gsic_pkg;

  localparam int DATA_W  = 32;               // Q16.16 word
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * DATA_W - FRAC_W; // floor(a*b / 2^16)
  localparam int SAT_W   = PROD_W + 1;       // headroom for one add before saturation
  localparam int CMD_W   = 17;               // command, 0..1.0
  localparam int LIMIT_W = 31;
  localparam int CFG_W   = 31;               // widest register
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W   = 2;
  localparam int IDX_W   = 4;                // coeff_index field

  localparam int POLY_TERMS_DEF = 8;

  localparam logic [ROW_W-1:0] ROW_REF = 2'd3; // reference velocity row

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UOPT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

  localparam logic [CMD_W-1:0]   UOPT_RESET  = 17'd32768;
  localparam logic [CMD_W-1:0]   DT_RESET    = 17'd655;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd655360;
  localparam logic [CMD_W-1:0]   CMD_ONE     = 17'd65536;

  // saturate to signed 32 bits: in range when the top bits all copy bit 31
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (&v[SAT_W-1:DATA_W-1] || ~|v[SAT_W-1:DATA_W-1]) begin
      r = v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[src/gsic_coeff_mem.sv]
module gsic_coeff_mem #(
  parameter int ADDR_W = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [gsic_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [gsic_pkg::DATA_W-1:0] rdata
);
  import gsic_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_q <= valid[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

[src/gsic_mul.sv]
module gsic_mul (
  input  logic                               clk,
  input  logic signed [gsic_pkg::DATA_W-1:0] a,
  input  logic signed [gsic_pkg::DATA_W-1:0] b,
  output logic signed [gsic_pkg::PROD_W-1:0] q
);
  import gsic_pkg::*;

  logic signed [2*DATA_W-1:0] prod;

  assign prod = (2*DATA_W)'(a) * (2*DATA_W)'(b);

  // arithmetic shift by dropping low bits: rounds toward minus infinity
  always_ff @(posedge clk) begin
    q <= prod[2*DATA_W-1:FRAC_W];
  end

endmodule

[src/gain_scheduled_incremental_controller_unit.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  kind, coeff_row, coeff_index, coeff_value,
//                                           height, velocity
// result    out        out_valid / out_stall control_output, reference_velocity,
//                                           output_clamped, integral_clamped
// config    in         cfg_write            cfg_index, cfg_data
//
// A load item writes the coefficient table and leaves the block idle. A sample item
// holds in_stall high while the one shared 32x32 multiplier runs every Horner step
// of the four rows and then the four control law products.
// rst is synchronous; it clears the coefficient table, the integral and the last
// command. A stalled result holds in the output register while the next item is
// taken; the finish step waits only if that register is still full.
module gain_scheduled_incremental_controller_unit #(
  parameter int POLY_TERMS = gsic_pkg::POLY_TERMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [gsic_pkg::ROW_W-1:0]            coeff_row,
  input  logic [gsic_pkg::IDX_W-1:0]            coeff_index,
  input  logic signed [gsic_pkg::DATA_W-1:0]    coeff_value,
  input  logic signed [gsic_pkg::DATA_W-1:0]    height,
  input  logic signed [gsic_pkg::DATA_W-1:0]    velocity,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [gsic_pkg::CMD_W-1:0]            control_output,
  output logic signed [gsic_pkg::DATA_W-1:0]    reference_velocity,
  output logic                                  output_clamped,
  output logic                                  integral_clamped,
  input  logic                                  cfg_write,
  input  logic [gsic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsic_pkg::CFG_W-1:0]            cfg_data
);
  import gsic_pkg::*;

  localparam int IDX_BITS = $clog2(POLY_TERMS);
  localparam int ADDR_W   = ROW_W + IDX_BITS;
  localparam int CMP_W    = IDX_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(POLY_TERMS - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_ERR  = 4'd4;
  localparam logic [3:0] ST_M0   = 4'd5;
  localparam logic [3:0] ST_A0   = 4'd6;
  localparam logic [3:0] ST_M1   = 4'd7;
  localparam logic [3:0] ST_A1   = 4'd8;
  localparam logic [3:0] ST_M2   = 4'd9;
  localparam logic [3:0] ST_A2   = 4'd10;
  localparam logic [3:0] ST_M3   = 4'd11;
  localparam logic [3:0] ST_A3   = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state, state_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [IDX_BITS-1:0] idx, idx_next;

  logic [CMD_W-1:0]   uopt;
  logic [CMD_W-1:0]   dt;
  logic [LIMIT_W-1:0] limit;

  logic signed [DATA_W-1:0] integ;
  logic [CMD_W-1:0]         prev;

  logic signed [DATA_W-1:0] h_q, v_q;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] rowval [4];
  logic signed [DATA_W-1:0] err;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SAT_W-1:0]  isum;

  logic in_accept, load_we, finish;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [DATA_W-1:0]        coef_raw;
  logic signed [DATA_W-1:0] coef;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] q;

  logic signed [SAT_W-1:0]  q_wide, coef_wide, hsum_wide, diff_wide;
  logic signed [DATA_W-1:0] hsum;
  logic signed [SUM_W-1:0]  q_sum, prev_sum;
  logic signed [SAT_W-1:0]  q_isum, integ_wide, limit_wide;
  logic signed [CMD_W:0]    dev;

  logic [CMD_W-1:0]         u_clamped;
  logic                     u_clip;
  logic signed [DATA_W-1:0] i_clamped;
  logic                     i_clip;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_we   = in_accept && (kind == KIND_LOAD) &&
                     ({1'b0, coeff_index} < CMP_W'(POLY_TERMS));
  assign waddr     = {coeff_row, coeff_index[IDX_BITS-1:0]};
  assign raddr     = {row_next, idx_next};
  assign finish    = (state == ST_DONE) && (!out_valid || !out_stall);

  gsic_coeff_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (load_we),
    .waddr (waddr),
    .wdata (coeff_value),
    .raddr (raddr),
    .rdata (coef_raw)
  );

  assign coef = coef_raw;

  gsic_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (q)
  );

  // Horner step: saturate product, add coefficient, saturate again
  always_comb begin
    q_wide    = SAT_W'(q);
    hsum_wide = SAT_W'(sat32(q_wide));
    coef_wide = SAT_W'(coef);
    hsum      = sat32(hsum_wide + coef_wide);
    diff_wide = SAT_W'(v_q) - SAT_W'(rowval[ROW_REF]);
    q_sum      = SUM_W'(q);
    prev_sum   = $signed({{(SUM_W-CMD_W){1'b0}}, prev});
    q_isum     = SAT_W'(q);
    integ_wide = SAT_W'(integ);
    limit_wide = $signed({{(SAT_W-LIMIT_W){1'b0}}, limit});
    dev        = $signed({1'b0, prev}) - $signed({1'b0, uopt});
  end

  always_comb begin
    mul_a = acc;
    mul_b = h_q;
    case (state)
      ST_M0: begin
        mul_a = rowval[0];
        mul_b = err;
      end
      ST_M1: begin
        mul_a = rowval[1];
        mul_b = integ;
      end
      ST_M2: begin
        mul_a = rowval[2];
        mul_b = DATA_W'(dev);
      end
      ST_M3: begin
        mul_a = $signed({{(DATA_W-CMD_W){1'b0}}, dt});
        mul_b = err;
      end
      default: begin
        mul_a = acc;
        mul_b = h_q;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && kind == KIND_SAMPLE) begin
          row_next   = '0;
          idx_next   = '0;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        idx_next   = IDX_BITS'(1);
        state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD: begin
        if (idx == IDX_LAST) begin
          idx_next = '0;
          if (row == ROW_REF) begin
            state_next = ST_ERR;
          end else begin
            row_next   = row + 1'b1;
            state_next = ST_INIT;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_ERR:  state_next = ST_M0;
      ST_M0:   state_next = ST_A0;
      ST_A0:   state_next = ST_M1;
      ST_M1:   state_next = ST_A1;
      ST_A1:   state_next = ST_M2;
      ST_M2:   state_next = ST_A2;
      ST_A2:   state_next = ST_M3;
      ST_M3:   state_next = ST_A3;
      ST_A3:   state_next = ST_DONE;
      ST_DONE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    u_clip    = 1'b0;
    u_clamped = sum[CMD_W-1:0];
    if (sum < 0) begin
      u_clamped = '0;
      u_clip    = 1'b1;
    end else if (sum > $signed({{(SUM_W-CMD_W){1'b0}}, CMD_ONE})) begin
      u_clamped = CMD_ONE;
      u_clip    = 1'b1;
    end
    i_clip    = 1'b0;
    i_clamped = isum[DATA_W-1:0];
    if (isum > limit_wide) begin
      i_clamped = DATA_W'(limit_wide);
      i_clip    = 1'b1;
    end else if (isum < -limit_wide) begin
      i_clamped = DATA_W'(-limit_wide);
      i_clip    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row       <= '0;
      idx       <= '0;
      uopt      <= UOPT_RESET;
      dt        <= DT_RESET;
      limit     <= LIMIT_RESET;
      integ     <= '0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      idx   <= idx_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_UOPT:  uopt  <= cfg_data[CMD_W-1:0];
          REG_DT:    dt    <= cfg_data[CMD_W-1:0];
          REG_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (finish) begin
        integ     <= i_clamped;
        prev      <= u_clamped;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      h_q <= height;
      v_q <= velocity;
    end
    case (state)
      ST_INIT: acc <= coef;
      ST_ADD: begin
        acc <= hsum;
        if (idx == IDX_LAST) begin
          rowval[row] <= hsum;
        end
      end
      ST_ERR: err  <= sat32(diff_wide);
      ST_A0:  sum  <= prev_sum - q_sum;
      ST_A1:  sum  <= sum - q_sum;
      ST_A2:  sum  <= sum - q_sum;
      ST_A3:  isum <= integ_wide + q_isum;
      default: ;
    endcase
    if (finish) begin
      control_output     <= u_clamped;
      reference_velocity <= rowval[ROW_REF];
      output_clamped     <= u_clip;
      integral_clamped   <= i_clip;
    end
  end

endmodule

[tb/sv/tb_gain_scheduled_incremental_controller_unit.sv]
`timescale 1ns / 1ps

module tb_gain_scheduled_incremental_controller_unit;
  import gsic_pkg::*;

  localparam int POLY_TERMS  = POLY_TERMS_DEF;
  localparam int DIR_N       = 24;
  localparam int PHASE_ITEMS = 320;
  localparam int SETTLE      = 8 * POLY_TERMS + 16;  // one sample plus margin
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG    = 4000;

  localparam logic [ROW_W-1:0] ROW_G0 = 2'd0;
  localparam logic [ROW_W-1:0] ROW_G1 = 2'd1;
  localparam logic [ROW_W-1:0] ROW_G2 = 2'd2;

  localparam logic [31:0] W_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN   = 32'h8000_0000;
  localparam logic [31:0] ONE_Q   = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic                     kind;
    logic [ROW_W-1:0]         row;
    logic [IDX_W-1:0]         slot;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] h;
    logic signed [DATA_W-1:0] v;
  } ctl_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] vref;
    logic                     oc;
    logic                     ic;
  } ctl_result_t;

  typedef struct packed {
    ctl_item_t   item;
    logic        check;
    ctl_result_t want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = 1'b0;
  logic [ROW_W-1:0]         coeff_row = '0;
  logic [IDX_W-1:0]         coeff_index = '0;
  logic signed [DATA_W-1:0] coeff_value = '0;
  logic signed [DATA_W-1:0] height = '0;
  logic signed [DATA_W-1:0] velocity = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CMD_W-1:0]         control_output;
  logic signed [DATA_W-1:0] reference_velocity;
  logic                     output_clamped;
  logic                     integral_clamped;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  // controller image kept by the testbench
  logic signed [DATA_W-1:0] coef_tab [4][POLY_TERMS];
  logic signed [DATA_W-1:0] integ;
  logic [CMD_W-1:0]         prev_cmd;
  logic [CMD_W-1:0]         uopt_reg;
  logic [CMD_W-1:0]         dt_reg;
  logic [LIMIT_W-1:0]       lim_reg;

  ctl_result_t awaited_results[$];
  ctl_result_t want_now;
  int          errors = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  int          quiet_cycles = 0;

  // kind, row, slot, value, height, velocity | typed check | cmd, vref, oc, ic
  dir_row_t dir_tab [DIR_N] = '{
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
      '{17'd0, 32'd0, 1'b0, 1'b0}},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, W_MAX, W_MAX}, 1'b1,
      '{17'd0, 32'd0, 1'b0, 1'b1}},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, W_MIN, W_MIN}, 1'b1,
      '{17'd0, 32'd0, 1'b0, 1'b1}},
    '{'{KIND_LOAD, ROW_REF, 4'd7, W_MAX, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'd0, W_MIN}, 1'b1,
      '{17'd0, W_MAX, 1'b0, 1'b1}},
    // slots past the last term are dropped
    '{'{KIND_LOAD, ROW_REF, 4'd8, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_REF, 4'd15, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'd5, W_MAX}, 1'b1,
      '{17'd0, W_MAX, 1'b0, 1'b0}},
    '{'{KIND_LOAD, ROW_REF, 4'd7, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_G0, 4'd7, NEG_ONE, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'd0, W_MAX}, 1'b1,
      '{CMD_ONE, 32'd0, 1'b1, 1'b1}},
    '{'{KIND_LOAD, ROW_G0, 4'd7, ONE_Q, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'd0, W_MAX}, 1'b1,
      '{17'd0, 32'd0, 1'b1, 1'b1}},
    '{'{KIND_LOAD, ROW_G0, 4'd0, W_MIN, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_G1, 4'd3, 32'h0002_0000, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_G2, 4'd6, 32'hFFFF_8000, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_REF, 4'd0, W_MAX, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_REF, 4'd1, W_MIN, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, W_MAX, W_MIN}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, W_MIN, W_MAX}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, 32'h0001_8000, 32'h1234_5678}, 1'b0, '0},
    '{'{KIND_LOAD, ROW_G1, 4'd7, 32'h0000_8000, 32'd0, 32'd0}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, NEG_ONE, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{KIND_SAMPLE, ROW_G0, 4'd0, 32'd0, ONE_Q, 32'd0}, 1'b0, '0}
  };

  gain_scheduled_incremental_controller_unit u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .coeff_row          (coeff_row),
    .coeff_index        (coeff_index),
    .coeff_value        (coeff_value),
    .height             (height),
    .velocity           (velocity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .control_output     (control_output),
    .reference_velocity (reference_velocity),
    .output_clamped     (output_clamped),
    .integral_clamped   (integral_clamped),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q16.16 product, floor of the exact product over 2^16
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic logic signed [DATA_W-1:0] clip32(input longint x);
    if (x > S32_MAX) return W_MAX;
    if (x < S32_MIN) return W_MIN;
    return 32'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] eval_row(input logic [ROW_W-1:0] row,
                                                        input logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] acc;
    acc = coef_tab[row][0];
    for (int i = 1; i < POLY_TERMS; i++) begin
      acc = clip32(qmul(longint'(acc), longint'(x)));
      acc = clip32(longint'(acc) + longint'(coef_tab[row][i]));
    end
    return acc;
  endfunction

  function automatic ctl_result_t control_step(input logic signed [DATA_W-1:0] h,
                                               input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] g0, g1, g2, vref, err;
    longint u, isum, lim;
    ctl_result_t r;
    g0   = eval_row(ROW_G0, h);
    g1   = eval_row(ROW_G1, h);
    g2   = eval_row(ROW_G2, h);
    vref = eval_row(ROW_REF, h);
    err  = clip32(longint'(v) - longint'(vref));
    u = longint'(prev_cmd) - qmul(longint'(g0), longint'(err))
        - qmul(longint'(g1), longint'(integ))
        - qmul(longint'(g2), longint'(prev_cmd) - longint'(uopt_reg));
    r.oc = 1'b0;
    r.ic = 1'b0;
    if (u < 0) begin
      u = 0;
      r.oc = 1'b1;
    end else if (u > longint'(CMD_ONE)) begin
      u = longint'(CMD_ONE);
      r.oc = 1'b1;
    end
    lim  = longint'(lim_reg);
    isum = longint'(integ) + qmul(longint'(dt_reg), longint'(err));
    if (isum > lim) begin
      isum = lim;
      r.ic = 1'b1;
    end else if (isum < -lim) begin
      isum = -lim;
      r.ic = 1'b1;
    end
    integ    = 32'(isum);
    prev_cmd = 17'(u);
    r.cmd    = 17'(u);
    r.vref   = vref;
    return r;
  endfunction

  // mostly within +-span, now and then wide, full range or an extreme
  function automatic logic [DATA_W-1:0] pick_word(input int span);
    case ($urandom_range(19))
      0:       return W_MAX;
      1:       return W_MIN;
      2, 3:    return $urandom;
      4, 5, 6: return 32'(int'($urandom_range(0, 2 * 64 * 65536)) - 64 * 65536);
      7:       return '0;
      default: return 32'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic send_item(input ctl_item_t it, input logic check, input ctl_result_t want);
    ctl_result_t got;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    coeff_row   <= it.row;
    coeff_index <= it.slot;
    coeff_value <= it.value;
    height      <= it.h;
    velocity    <= it.v;
    do @(posedge clk); while (in_stall);
    if (it.kind == KIND_LOAD) begin
      if (it.slot < POLY_TERMS) coef_tab[it.row][it.slot] = it.value;
    end else begin
      got = control_step(it.h, it.v);
      awaited_results.push_back(check ? want : got);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CMD_W-1:0] uopt, input logic [CMD_W-1:0] dt,
                            input logic [LIMIT_W-1:0] lim);
    write_reg(REG_UOPT, CFG_W'(uopt));
    write_reg(REG_DT, CFG_W'(dt));
    write_reg(REG_LIMIT, CFG_W'(lim));
    cfg_write <= 1'b0;
    uopt_reg = uopt;
    dt_reg   = dt;
    lim_reg  = lim;
  endtask

  task automatic random_run(input int count);
    ctl_item_t   it;
    ctl_result_t none;
    int          left;
    int          loads;
    left = count;
    none = '0;
    while (left > 0) begin
      it.h     = pick_word(65536);
      it.v     = pick_word(16384);
      it.row   = ROW_W'($urandom_range(3));
      it.slot  = IDX_W'($urandom_range(15));
      it.value = $urandom;
      case ($urandom_range(9))
        0, 1: begin
          // reprogram one row, sometimes cut short
          loads = ($urandom_range(3) == 0) ? $urandom_range(1, POLY_TERMS - 1) : POLY_TERMS;
          it.kind = KIND_LOAD;
          for (int i = 0; i < loads; i++) begin
            it.slot  = IDX_W'(i);
            it.value = pick_word(32768);
            send_item(it, 1'b0, none);
            left--;
          end
        end
        2: begin
          it.kind = KIND_LOAD;
          send_item(it, 1'b0, none);
          if (it.slot < POLY_TERMS) left--;
        end
        default: begin
          it.kind = KIND_SAMPLE;
          send_item(it, 1'b0, none);
          left--;
        end
      endcase
    end
  endtask

  initial begin
    foreach (coef_tab[r, i]) coef_tab[r][i] = '0;
    integ    = '0;
    prev_cmd = '0;
    uopt_reg = UOPT_RESET;
    dt_reg   = DT_RESET;
    lim_reg  = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < DIR_N; n++) begin
      send_item(dir_tab[n].item, dir_tab[n].check, dir_tab[n].want);
    end
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: set_config('0, '0, '0);
          2: set_config(CMD_ONE, CMD_ONE, {LIMIT_W{1'b1}});
          4: set_config({CMD_W{1'b1}}, {CMD_W{1'b1}}, LIMIT_W'($urandom_range(0, 32'h7FFF_FFFF)));
          default: set_config(CMD_W'($urandom_range(0, 65536)), CMD_W'($urandom_range(0, 65536)),
                              LIMIT_W'($urandom_range(0, 40 * 65536)));
        endcase
      end
      calm = (ph == 2);
      random_run(PHASE_ITEMS);
    end
    drain();
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with no item pending, cmd %0d vref %0d", $time,
                 control_output, reference_velocity);
        errors++;
      end else begin
        want_now = awaited_results.pop_front();
        if (control_output !== want_now.cmd) begin
          $display("%0t ns: control_output expected %0d got %0d", $time, want_now.cmd,
                   control_output);
          errors++;
        end
        if (reference_velocity !== want_now.vref) begin
          $display("%0t ns: reference_velocity expected %0d got %0d", $time, want_now.vref,
                   reference_velocity);
          errors++;
        end
        if (output_clamped !== want_now.oc) begin
          $display("%0t ns: output_clamped expected %0b got %0b", $time, want_now.oc,
                   output_clamped);
          errors++;
        end
        if (integral_clamped !== want_now.ic) begin
          $display("%0t ns: integral_clamped expected %0b got %0b", $time, want_now.ic,
                   integral_clamped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG) begin
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

[sim.f]
src/gsic_pkg.sv
src/gsic_coeff_mem.sv
src/gsic_mul.sv
src/gain_scheduled_incremental_controller_unit.sv
tb/sv/tb_gain_scheduled_incremental_controller_unit.sv
